>>> sv/pfla_pkg.sv
package pfla_pkg;

	// Pool geometry.
	localparam int NUM_PAGES = 1024;
	localparam int IDX_W     = $clog2(NUM_PAGES);
	localparam int PAGE_W    = $clog2(NUM_PAGES + 1);

	// Field widths.
	localparam int ADDR_W   = 32;
	localparam int SHIFT_W  = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;
	localparam int M_DATA_W = 48;

	// Configuration register indexes.
	localparam logic REG_BASE_ADDRESS = 1'b0;
	localparam logic REG_PAGE_SHIFT   = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);

	// Operation codes.
	localparam logic OP_ALLOC  = 1'b0;
	localparam logic OP_RETURN = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

	// Controller to datapath commands.
	typedef struct packed {
		logic clear_en;
		logic capture;
		logic commit;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clear_last;
	} dp_sts_t;

endpackage

>>> sv/page_free_list_allocator.sv
// A request transaction is captured into the request registers, and its result is
// committed to the master side once the result register has been drained.
// A new request is accepted only after the previous one has been committed
// (s_tready is high only in the idle state); the commit updates the head page.
// Reset: asynchronous; afterwards a pass writes the initial chain into every
// entry of the link memory while s_tready stays low (configuration writes work).
module page_free_list_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] page_address
	input  logic        s_tuser,   // [0] operation
	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] alloc_address, [42:32] free_count, rest zero
	output logic [1:0]  m_tuser,   // [1:0] status
	// Configuration write port.
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import pfla_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	logic [ADDR_W-1:0]   base_address_q;
	logic [SHIFT_W-1:0]  page_shift_q;
	logic [ADDR_W-1:0]   alloc_address;
	logic [COUNT_W-1:0]  free_count;

	// Configuration registers. Writes are only expected while no transaction
	// is in flight, so they need no interlock with the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= BASE_RESET;
			page_shift_q   <= SHIFT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BASE_ADDRESS: base_address_q <= cfg_data;
				REG_PAGE_SHIFT:   page_shift_q   <= cfg_data[SHIFT_W-1:0];
				default:          base_address_q <= base_address_q;
			endcase
		end
	end

	// The controller sequences the clearing pass, the capture of a request
	// transaction, and the commit of its result into the output register.
	pfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the link memory, head page, free count and the
	// result register.
	pfla_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.base_address  (base_address_q),
		.page_shift    (page_shift_q),
		.operation     (s_tuser),
		.page_address  (s_tdata),
		.status        (m_tuser),
		.alloc_address (alloc_address),
		.free_count    (free_count)
	);

	assign m_tdata = {(M_DATA_W - ADDR_W - COUNT_W)'(0), free_count, alloc_address};

endmodule

>>> sv/pfla_ctrl.sv
module pfla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  pfla_pkg::dp_sts_t sts,
	output pfla_pkg::dp_cmd_t cmd
);
	import pfla_pkg::*;

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	// The result register can take a new result when empty or being drained.
	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			ST_INIT: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("commit did not load the result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd.commit)
		else $error("pending result overwritten");

	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_EXEC))
		else $error("captured request not executed");

endmodule

>>> sv/pfla_dp.sv
module pfla_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfla_pkg::dp_cmd_t              cmd,
	output pfla_pkg::dp_sts_t              sts,
	input  logic [pfla_pkg::ADDR_W-1:0]    base_address,
	input  logic [pfla_pkg::SHIFT_W-1:0]   page_shift,
	input  logic                           operation,
	input  logic [pfla_pkg::ADDR_W-1:0]    page_address,
	output logic [pfla_pkg::STATUS_W-1:0]  status,
	output logic [pfla_pkg::ADDR_W-1:0]    alloc_address,
	output logic [pfla_pkg::COUNT_W-1:0]   free_count
);
	import pfla_pkg::*;

	// Next-page links, entry i belongs to page i+1.
	logic [PAGE_W-1:0] link_mem [NUM_PAGES];

	logic [IDX_W-1:0]  clear_idx_q;
	logic [PAGE_W-1:0] head_q;
	logic [PAGE_W-1:0] count_q;
	logic [PAGE_W-1:0] link_rd_q;

	logic              op_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              range_bad_s1;

	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   alloc_q;
	logic [COUNT_W-1:0]  count_out_q;

	logic [ADDR_W-1:0] ret_offset;
	logic [ADDR_W-1:0] ret_shifted;
	logic [IDX_W-1:0]  head_idx;
	logic [ADDR_W-1:0] alloc_sum;
	logic              head_bad;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [PAGE_W-1:0]   wr_data;
	logic [PAGE_W-1:0]   clear_val;
	logic [STATUS_W-1:0] stat_d;
	logic [PAGE_W-1:0]   head_d;
	logic [PAGE_W-1:0]   count_d;
	logic                push;

	assign sts.clear_last = (clear_idx_q == IDX_W'(NUM_PAGES - 1));

	// Power-on chain: each page points at the next one, the last one ends it.
	assign clear_val = sts.clear_last ? '0 : (PAGE_W'(clear_idx_q) + PAGE_W'(2));

	// Return path: byte address to page index, done while capturing.
	assign ret_offset  = page_address - base_address;
	assign ret_shifted = ret_offset >> page_shift;

	// Allocate path: address of the head page.
	assign head_idx  = IDX_W'(head_q - PAGE_W'(1));
	assign alloc_sum = base_address + (ADDR_W'(head_idx) << page_shift);
	assign head_bad  = (count_q == '0) || (head_q == '0) ||
		(head_q > PAGE_W'(NUM_PAGES));

	always_comb begin
		stat_d  = STAT_OK;
		head_d  = head_q;
		count_d = count_q;
		push    = 1'b0;
		if (op_s1 == OP_ALLOC) begin
			if (head_bad) begin
				stat_d = STAT_EMPTY;
			end else begin
				head_d  = link_rd_q;
				count_d = count_q - PAGE_W'(1);
			end
		end else begin
			if (count_q >= PAGE_W'(NUM_PAGES)) begin
				stat_d = STAT_FULL;
			end else if (range_bad_s1) begin
				stat_d = STAT_RANGE;
			end else begin
				push    = 1'b1;
				head_d  = PAGE_W'(idx_s1) + PAGE_W'(1);
				count_d = count_q + PAGE_W'(1);
			end
		end
	end

	assign wr_en   = cmd.clear_en || (cmd.commit && push);
	assign wr_idx  = cmd.clear_en ? clear_idx_q : idx_s1;
	assign wr_data = cmd.clear_en ? clear_val : head_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_idx] <= wr_data;
		end
		link_rd_q <= link_mem[head_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_idx_q <= '0;
			head_q      <= PAGE_W'(1);
			count_q     <= PAGE_W'(NUM_PAGES);
		end else begin
			if (cmd.clear_en) begin
				clear_idx_q <= clear_idx_q + IDX_W'(1);
			end
			if (cmd.commit) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1        <= operation;
			idx_s1       <= ret_shifted[IDX_W-1:0];
			range_bad_s1 <= (ret_shifted > ADDR_W'(NUM_PAGES - 1));
		end
		if (cmd.commit) begin
			status_q    <= stat_d;
			alloc_q     <= (stat_d == STAT_OK && op_s1 == OP_ALLOC) ? alloc_sum : '0;
			count_out_q <= COUNT_W'(count_d);
		end
	end

	assign status        = status_q;
	assign alloc_address = alloc_q;
	assign free_count    = count_out_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PAGE_W'(NUM_PAGES))
		else $error("free page count above pool size");

	a_head_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= PAGE_W'(NUM_PAGES))
		else $error("head page outside the pool");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && push) |=> (count_q == $past(count_q) + PAGE_W'(1)))
		else $error("push did not raise the free count");

endmodule
